// ----- rtl/core/pnms_pkg.sv -----
// Shared widths, codes and interface structs for the pixel noise statistics block.
package pnms_pkg;

    localparam int PIXEL_ADDR_BITS = 22;
    localparam int PIXEL_BITS      = 16;
    localparam int MAX_FRAMES      = 1024;

    localparam int ADDR_W    = PIXEL_ADDR_BITS;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int PIX_W     = PIXEL_BITS;
    localparam int FRAME_W   = $clog2(MAX_FRAMES);
    localparam int SUM_W     = PIX_W + FRAME_W;
    localparam int SQ_W      = 2 * PIX_W + FRAME_W;
    localparam int ENTRY_W   = SUM_W + SQ_W;
    localparam int N_W       = 11;
    localparam int OUT_W     = 24;
    localparam int CFG_W     = 24;
    localparam int PROD_W    = N_W + SQ_W;
    localparam int SSQ_W     = 2 * SUM_W;
    localparam int DEN_W     = 2 * N_W;
    localparam int Q_W       = 2 * OUT_W;
    localparam int VAR_FRAC  = 16;
    localparam int OVF_SHIFT = Q_W - VAR_FRAC;
    localparam int MEAN_FRAC = 8;
    localparam int ROOT_W    = Q_W / 2;

    localparam int N_MIN           = 2;
    localparam int FRAME_COUNT_RST = 100;
    localparam int THRESHOLD_RST   = 768;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 1'b0,
        CFG_THRESHOLD   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   t2;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [SUM_W-1:0]  s;
        logic [SQ_W-1:0]   s2;
    } t_rd_req;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic              bad;
        logic [OUT_W-1:0]  mean;
        logic [OUT_W-1:0]  sigma;
    } t_rd_res;

endpackage

// ----- rtl/core/pnms_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, then read old contents on a same-address access
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pnms_stats_pipe.sv -----
// Pipelined mean, variance division, square root and threshold compare for readouts.
module pnms_stats_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  pnms_pkg::t_rd_req  i_req,
    input  pnms_pkg::t_cfg     i_cfg,
    output logic               o_valid,
    output pnms_pkg::t_rd_res  o_res
);

    localparam int DIV_STEPS  = pnms_pkg::Q_W;
    localparam int SQRT_STEPS = pnms_pkg::ROOT_W;
    localparam int Q_W        = pnms_pkg::Q_W;
    localparam int VREM_W     = pnms_pkg::DEN_W;
    localparam int MREM_W     = pnms_pkg::N_W;
    localparam int SREM_W     = pnms_pkg::ROOT_W + 1;
    localparam int ROOT_W     = pnms_pkg::ROOT_W;
    localparam int PROD_W     = pnms_pkg::PROD_W;
    localparam int SSQ_W      = pnms_pkg::SSQ_W;
    localparam int ADDR_W     = pnms_pkg::ADDR_W;
    localparam int SUM_W      = pnms_pkg::SUM_W;
    localparam int OUT_W      = pnms_pkg::OUT_W;
    localparam int MPAD       = Q_W - SUM_W - pnms_pkg::MEAN_FRAC;
    localparam int OVF_SHIFT  = pnms_pkg::OVF_SHIFT;
    localparam int DEN_SH_W   = pnms_pkg::DEN_W + OVF_SHIFT;

    // front stages
    logic                r_p1_valid;
    pnms_pkg::t_rd_req   r_p1;
    logic                r_p2_valid;
    logic [ADDR_W-1:0]   r_p2_idx;
    logic [SUM_W-1:0]    r_p2_s;
    logic [PROD_W-1:0]   r_p2_a;
    logic [SSQ_W-1:0]    r_p2_b;
    logic                r_p3_valid;
    logic [ADDR_W-1:0]   r_p3_idx;
    logic [SUM_W-1:0]    r_p3_s;
    logic [PROD_W-1:0]   r_p3_num;

    // divider stages
    logic                r_dv_valid [DIV_STEPS+1];
    logic [ADDR_W-1:0]   r_dv_idx   [DIV_STEPS+1];
    logic                r_dv_ovf   [DIV_STEPS+1];
    logic [VREM_W-1:0]   r_vrem     [DIV_STEPS+1];
    logic [Q_W-1:0]      r_vdq      [DIV_STEPS+1];
    logic [MREM_W-1:0]   r_mrem     [DIV_STEPS+1];
    logic [Q_W-1:0]      r_mdq      [DIV_STEPS+1];
    logic [VREM_W-1:0]   n_vrem     [DIV_STEPS];
    logic [Q_W-1:0]      n_vdq      [DIV_STEPS];
    logic [MREM_W-1:0]   n_mrem     [DIV_STEPS];
    logic [Q_W-1:0]      n_mdq      [DIV_STEPS];
    logic [VREM_W:0]     w_vt       [DIV_STEPS];
    logic [MREM_W:0]     w_mt       [DIV_STEPS];
    logic                w_vge      [DIV_STEPS];
    logic                w_mge      [DIV_STEPS];

    // square root stages
    logic                r_sq_valid [SQRT_STEPS+1];
    logic [ADDR_W-1:0]   r_sq_idx   [SQRT_STEPS+1];
    logic                r_sq_ovf   [SQRT_STEPS+1];
    logic                r_sq_bad   [SQRT_STEPS+1];
    logic [OUT_W-1:0]    r_sq_mean  [SQRT_STEPS+1];
    logic [Q_W-1:0]      r_sx       [SQRT_STEPS+1];
    logic [ROOT_W-1:0]   r_sroot    [SQRT_STEPS+1];
    logic [SREM_W-1:0]   r_srem     [SQRT_STEPS+1];
    logic [SREM_W+1:0]   w_st       [SQRT_STEPS];
    logic [SREM_W+1:0]   w_tr       [SQRT_STEPS];
    logic                w_sge      [SQRT_STEPS];

    logic [PROD_W-1:0]   w_num;
    logic                w_ovf;
    logic [Q_W-1:0]      w_q;
    logic                w_frac;
    logic                w_bad;
    logic [OUT_W-1:0]    w_mean;

    // difference of the products, clamped at zero
    assign w_num = (r_p2_a > PROD_W'(r_p2_b)) ? (r_p2_a - PROD_W'(r_p2_b)) : '0;

    // quotient would not fit below 2^32 in integer part
    assign w_ovf = (DEN_SH_W'(r_p3_num) >= {i_cfg.den, {OVF_SHIFT{1'b0}}});

    // one restoring step per stage for both dividers
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            w_vt[k]   = {r_vrem[k], r_vdq[k][Q_W-1]};
            w_vge[k]  = (w_vt[k] >= {1'b0, i_cfg.den});
            n_vrem[k] = w_vge[k] ? VREM_W'(w_vt[k] - {1'b0, i_cfg.den})
                                 : w_vt[k][VREM_W-1:0];
            n_vdq[k]  = {r_vdq[k][Q_W-2:0], w_vge[k]};
            w_mt[k]   = {r_mrem[k], r_mdq[k][Q_W-1]};
            w_mge[k]  = (w_mt[k] >= {1'b0, i_cfg.n});
            n_mrem[k] = w_mge[k] ? MREM_W'(w_mt[k] - {1'b0, i_cfg.n})
                                 : w_mt[k][MREM_W-1:0];
            n_mdq[k]  = {r_mdq[k][Q_W-2:0], w_mge[k]};
        end
    end

    // finish division: flag and mean saturation
    assign w_q    = r_vdq[DIV_STEPS];
    assign w_frac = (r_vrem[DIV_STEPS] != '0);
    assign w_bad  = r_dv_ovf[DIV_STEPS] || (w_q > i_cfg.t2) || ((w_q == i_cfg.t2) && w_frac);
    assign w_mean = (r_mdq[DIV_STEPS][Q_W-1:OUT_W] != '0) ? '1
                                                         : r_mdq[DIV_STEPS][OUT_W-1:0];

    // one root bit per stage
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_st[k]  = {r_srem[k], r_sx[k][Q_W-1:Q_W-2]};
            w_tr[k]  = {1'b0, r_sroot[k], 2'b01};
            w_sge[k] = (w_st[k] >= w_tr[k]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                r_sq_valid[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_p1_valid    <= i_valid;
            r_p2_valid    <= r_p1_valid;
            r_p3_valid    <= r_p2_valid;
            r_dv_valid[0] <= r_p3_valid;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            r_sq_valid[0] <= r_dv_valid[DIV_STEPS];
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
        end
    end

    // payload, advanced with the valid bits
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p1     <= i_req;
            r_p2_idx <= r_p1.idx;
            r_p2_s   <= r_p1.s;
            r_p2_a   <= PROD_W'(i_cfg.n) * PROD_W'(r_p1.s2);
            r_p2_b   <= SSQ_W'(r_p1.s) * SSQ_W'(r_p1.s);
            r_p3_idx <= r_p2_idx;
            r_p3_s   <= r_p2_s;
            r_p3_num <= w_num;

            r_dv_idx[0] <= r_p3_idx;
            r_dv_ovf[0] <= w_ovf;
            r_vrem[0]   <= VREM_W'(r_p3_num[PROD_W-1:OVF_SHIFT]);
            r_vdq[0]    <= {r_p3_num[OVF_SHIFT-1:0], {pnms_pkg::VAR_FRAC{1'b0}}};
            r_mrem[0]   <= '0;
            r_mdq[0]    <= {{MPAD{1'b0}}, r_p3_s, {pnms_pkg::MEAN_FRAC{1'b0}}};
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv_idx[k+1] <= r_dv_idx[k];
                r_dv_ovf[k+1] <= r_dv_ovf[k];
                r_vrem[k+1]   <= n_vrem[k];
                r_vdq[k+1]    <= n_vdq[k];
                r_mrem[k+1]   <= n_mrem[k];
                r_mdq[k+1]    <= n_mdq[k];
            end

            r_sq_idx[0]  <= r_dv_idx[DIV_STEPS];
            r_sq_ovf[0]  <= r_dv_ovf[DIV_STEPS];
            r_sq_bad[0]  <= w_bad;
            r_sq_mean[0] <= w_mean;
            r_sx[0]      <= w_q;
            r_sroot[0]   <= '0;
            r_srem[0]    <= '0;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sq_idx[k+1]  <= r_sq_idx[k];
                r_sq_ovf[k+1]  <= r_sq_ovf[k];
                r_sq_bad[k+1]  <= r_sq_bad[k];
                r_sq_mean[k+1] <= r_sq_mean[k];
                r_sx[k+1]      <= {r_sx[k][Q_W-3:0], 2'b00};
                r_sroot[k+1]   <= {r_sroot[k][ROOT_W-2:0], w_sge[k]};
                r_srem[k+1]    <= w_sge[k] ? SREM_W'(w_st[k] - w_tr[k])
                                           : w_st[k][SREM_W-1:0];
            end
        end
    end

    assign o_valid     = r_sq_valid[SQRT_STEPS];
    assign o_res.idx   = r_sq_idx[SQRT_STEPS];
    assign o_res.bad   = r_sq_bad[SQRT_STEPS];
    assign o_res.mean  = r_sq_mean[SQRT_STEPS];
    assign o_res.sigma = r_sq_ovf[SQRT_STEPS] ? '1 : r_sroot[SQRT_STEPS];

endmodule

// ----- rtl/core/pixel_noise_mask_statistics_core.sv -----
// Top level: per-pixel sum store, accumulate and clear, readout statistics and bad flag.
//
// Input channel (i_valid / o_ready) carries one request: accumulate a sample, read
// out a pixel, or clear a pixel. Op code 3 is dropped. Only a readout gives a result
// on the output channel (o_valid / i_ready): pixel index, mean and sample deviation
// in unsigned Q8, and a bad flag when the deviation exceeds the threshold.
// Throughput is one request per cycle of any kind while o_ready is high; the single
// memory is read at accept and written back from the memory stage, with a one-entry
// forward so requests to the same pixel may follow each other directly.
// A readout result passes through the memory stage, the front stages, the 48-step
// pipelined divider, the 24-step pipelined square root and the output register.
// After reset a clearing pass zeroes all 4194304 entries of the store, one entry per
// cycle; o_ready stays low during it, configuration writes are still taken.
// Configuration (frame count, threshold) is written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must do so only while the block is idle, the block does not enforce it.
// When the receiver stalls, the output register holds its result and the pipeline
// keeps moving into empty slots; it freezes, and o_ready drops, only when a finished
// result is waiting behind the held one.
module pixel_noise_mask_statistics_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [pnms_pkg::ADDR_W-1:0]         i_pixel_index,
    input  logic [pnms_pkg::PIX_W-1:0]          i_pixel_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pnms_pkg::ADDR_W-1:0]         o_pixel_ref,
    output logic                                o_is_bad,
    output logic [pnms_pkg::OUT_W-1:0]          o_mean_q8,
    output logic [pnms_pkg::OUT_W-1:0]          o_sigma_q8,
    input  logic                                i_cfg_we,
    input  logic [pnms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pnms_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int ADDR_W  = pnms_pkg::ADDR_W;
    localparam int PIX_W   = pnms_pkg::PIX_W;
    localparam int SUM_W   = pnms_pkg::SUM_W;
    localparam int SQ_W    = pnms_pkg::SQ_W;
    localparam int ENTRY_W = pnms_pkg::ENTRY_W;
    localparam int N_W     = pnms_pkg::N_W;
    localparam int OUT_W   = pnms_pkg::OUT_W;
    localparam int DEN_W   = pnms_pkg::DEN_W;
    localparam int Q_W     = pnms_pkg::Q_W;

    // configuration
    logic [N_W-1:0]      r_frame_count;
    logic [OUT_W-1:0]    r_threshold;
    pnms_pkg::t_cfg      r_cfg;

    // clearing pass
    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_addr;

    // memory stage
    logic                r_s1_valid;
    logic [1:0]          r_s1_op;
    logic [ADDR_W-1:0]   r_s1_idx;
    logic [PIX_W-1:0]    r_s1_val;
    logic [2*PIX_W-1:0]  r_s1_sq;
    logic                r_fw_valid;
    logic [ADDR_W-1:0]   r_fw_addr;
    logic [ENTRY_W-1:0]  r_fw_data;

    // output register
    logic                r_out_valid;
    pnms_pkg::t_rd_res   r_out;

    logic                w_acc;
    logic                w_adv;
    logic                w_stall;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [ENTRY_W-1:0]  w_entry;
    logic [SUM_W-1:0]    w_s;
    logic [SQ_W-1:0]     w_s2;
    logic [SUM_W:0]      w_sum_ext;
    logic [SQ_W:0]       w_sq_ext;
    logic [ENTRY_W-1:0]  w_new;
    logic                w_upd;
    logic                w_wr;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic [ENTRY_W-1:0]  w_ram_wdata;
    logic                w_pipe_in_valid;
    pnms_pkg::t_rd_req   w_req;
    logic                w_pipe_valid;
    pnms_pkg::t_rd_res   w_pipe_res;

    // handshake: freeze only when a finished result queues behind a held one
    assign w_stall = r_out_valid && !i_ready && w_pipe_valid;
    assign w_adv   = !w_stall;
    assign o_ready = !r_clearing && w_adv;
    assign w_acc   = i_valid && o_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= N_W'(pnms_pkg::FRAME_COUNT_RST);
            r_threshold   <= OUT_W'(pnms_pkg::THRESHOLD_RST);
        end else if (i_cfg_we) begin
            unique case (pnms_pkg::t_cfg_idx'(i_cfg_index))
                pnms_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[N_W-1:0];
                pnms_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // derived constants: clamped n, n(n-1), squared threshold
    always_ff @(posedge i_clk) begin
        r_cfg.n   <= (r_frame_count < N_W'(pnms_pkg::N_MIN)) ? N_W'(pnms_pkg::N_MIN)
                                                              : r_frame_count;
        r_cfg.den <= DEN_W'(r_cfg.n) * DEN_W'(r_cfg.n - N_W'(1));
        r_cfg.t2  <= Q_W'(r_threshold) * Q_W'(r_threshold);
    end

    // zero the store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // capture request as its entry is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_op  <= i_op;
            r_s1_idx <= i_pixel_index;
            r_s1_val <= i_pixel_value;
            r_s1_sq  <= (2*PIX_W)'(i_pixel_value) * (2*PIX_W)'(i_pixel_value);
        end
    end

    // forward the last write over the stale read
    assign w_entry = (r_fw_valid && (r_fw_addr == r_s1_idx)) ? r_fw_data : w_rdata;
    assign w_s     = w_entry[SUM_W-1:0];
    assign w_s2    = w_entry[ENTRY_W-1:SUM_W];

    // saturating update
    assign w_sum_ext = {1'b0, w_s} + (SUM_W+1)'(r_s1_val);
    assign w_sq_ext  = {1'b0, w_s2} + (SQ_W+1)'(r_s1_sq);

    always_comb begin
        w_upd = 1'b0;
        w_new = '0;
        unique case (pnms_pkg::t_op'(r_s1_op))
            pnms_pkg::OP_ACCUM: begin
                w_upd = 1'b1;
                w_new = {(w_sq_ext[SQ_W] ? {SQ_W{1'b1}} : w_sq_ext[SQ_W-1:0]),
                         (w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0])};
            end
            pnms_pkg::OP_CLEAR: begin
                w_upd = 1'b1;
                w_new = '0;
            end
            default: begin
                w_upd = 1'b0;
                w_new = '0;
            end
        endcase
    end

    assign w_wr = r_s1_valid && w_upd && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (w_wr) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fw_addr <= r_s1_idx;
            r_fw_data <= w_new;
        end
    end

    // write port: clearing pass or write-back
    assign w_ram_we    = r_clearing || w_wr;
    assign w_ram_waddr = r_clearing ? r_clr_addr : r_s1_idx;
    assign w_ram_wdata = r_clearing ? '0 : w_new;

    pnms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (pnms_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_acc),
        .i_raddr (i_pixel_index),
        .o_rdata (w_rdata)
    );

    // hand readouts to the statistics pipeline
    assign w_pipe_in_valid = r_s1_valid && (r_s1_op == pnms_pkg::OP_READ);
    assign w_req.idx = r_s1_idx;
    assign w_req.s   = w_s;
    assign w_req.s2  = w_s2;

    pnms_stats_pipe u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_pipe_in_valid),
        .i_req   (w_req),
        .i_cfg   (r_cfg),
        .o_valid (w_pipe_valid),
        .o_res   (w_pipe_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_pipe_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pipe_valid) begin
            r_out <= w_pipe_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_ref = r_out.idx;
    assign o_is_bad    = r_out.bad;
    assign o_mean_q8   = r_out.mean;
    assign o_sigma_q8  = r_out.sigma;

    // no request enters while the store is being cleared
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_ready)
        else $error("request accepted during clearing pass");

    // clearing pass and write-back never compete for the write port
    a_clear_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("memory stage busy during clearing pass");

    // an accepted request reaches the memory stage
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_valid)
        else $error("accepted request lost before memory stage");

    // a queued result is not dropped while frozen
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stall && i_rst_n) |=> (w_pipe_valid && r_out_valid))
        else $error("result lost during stall");

endmodule
